/* hdl/tifp_pkg.sv */
// Shared types, constants and helpers for the terminal inbound field parser.
// No dependencies; imported by every module of the block.
package tifp_pkg;

   localparam int OFFSET_WIDTH      = 12;
   localparam int ADDR_WIDTH        = 12;
   localparam int MAX_RESULTS       = 3;
   localparam int COUNT_WIDTH       = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH       = 8;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_WIDTH = QUEUE_PTR_WIDTH + 1;
   localparam int HOLD_DEPTH        = 3;
   localparam int HOLD_IDX_WIDTH    = $clog2(HOLD_DEPTH);

   localparam logic [7:0]              SBA_ORDER  = 8'h11;
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_DATA,
      KIND_DONE,
      KIND_STATUS
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_TOO_SHORT,
      STATUS_BAD_ORDER
   } status_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       end_of_message;
   } item_type;

   typedef struct packed {
      kind_type                kind;
      logic [7:0]              attention_id;
      logic [ADDR_WIDTH-1:0]   cursor_offset;
      logic [ADDR_WIDTH-1:0]   field_address;
      logic [OFFSET_WIDTH-1:0] field_offset;
      logic [7:0]              data_value;
      status_type              status;
      logic                    final_result;
   } result_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]              count;
      result_type [MAX_RESULTS-1:0]        res;
   } bundle_type;

   typedef struct packed {
      logic                         room;
      logic [QUEUE_LEVEL_WIDTH-1:0] level;
   } queue_status_type;

   // Buffer address from two address bytes: low six bits of each byte.
   function automatic logic [ADDR_WIDTH-1:0] decode_addr(input logic [7:0] hi,
                                                         input logic [7:0] lo);
      return {hi[5:0], lo[5:0]};
   endfunction

   function automatic result_type make_result(input kind_type                kind,
                                              input logic [7:0]              aid,
                                              input logic [ADDR_WIDTH-1:0]   cur,
                                              input logic [ADDR_WIDTH-1:0]   addr,
                                              input logic [OFFSET_WIDTH-1:0] off,
                                              input logic [7:0]              data,
                                              input status_type              st);
      result_type r;
      r.kind          = kind;
      r.attention_id  = aid;
      r.cursor_offset = cur;
      r.field_address = addr;
      r.field_offset  = off;
      r.data_value    = data;
      r.status        = st;
      r.final_result  = 1'b0;
      return r;
   endfunction

endpackage

/* hdl/tifp_parser.sv */
// Parser state machine: turns one message byte into up to three results.
// Depends on tifp_pkg.
module tifp_parser
   import tifp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       process,
   input  item_type   item,
   output bundle_type bundle
);

   typedef enum logic [2:0] {
      PH_AID,
      PH_CUR1,
      PH_CUR2,
      PH_BODY,
      PH_SKIP
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]    held_count_ff, held_count_in;
   logic [7:0]                held_bytes_ff [HOLD_DEPTH];
   logic [7:0]                held_bytes_in [HOLD_DEPTH];
   logic [7:0]                saved_att_ff, saved_att_in;
   logic [ADDR_WIDTH-1:0]     saved_cur_ff, saved_cur_in;
   logic [ADDR_WIDTH-1:0]     cur_field_ff, cur_field_in;
   logic [OFFSET_WIDTH-1:0]   byte_off_ff, byte_off_in;
   logic                      in_field_ff, in_field_in;

   always_comb begin
      logic [COUNT_WIDTH-1:0] n;
      logic                   scan_now;
      logic                   finish_ok;
      logic [7:0]             b;
      logic                   eom;

      n         = '0;
      scan_now  = 1'b0;
      finish_ok = 1'b0;
      b         = item.stream_byte;
      eom       = item.end_of_message;

      phase_in      = phase_ff;
      held_count_in = held_count_ff;
      held_bytes_in = held_bytes_ff;
      saved_att_in  = saved_att_ff;
      saved_cur_in  = saved_cur_ff;
      cur_field_in  = cur_field_ff;
      byte_off_in   = byte_off_ff;
      in_field_in   = in_field_ff;
      bundle        = '0;

      if (process) begin
         case (phase_ff)
            PH_CUR1: begin
               held_bytes_in[0] = b;
               if (eom) begin
                  saved_att_in  = '0;
                  saved_cur_in  = '0;
                  bundle.res[n] = make_result(KIND_STATUS, '0, '0, '0, '0, '0,
                                              STATUS_TOO_SHORT);
                  n             = n + 1'b1;
                  phase_in      = PH_AID;
                  in_field_in   = 1'b0;
                  held_count_in = '0;
               end else begin
                  phase_in = PH_CUR2;
               end
            end
            PH_CUR2: begin
               saved_cur_in  = decode_addr(held_bytes_ff[0], b);
               bundle.res[n] = make_result(KIND_HEADER, saved_att_ff, saved_cur_in,
                                           '0, '0, '0, STATUS_OK);
               n             = n + 1'b1;
               in_field_in   = 1'b0;
               held_count_in = '0;
               if (eom) begin
                  finish_ok = 1'b1;
               end else begin
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               if (in_field_ff) begin
                  scan_now = 1'b1;
               end else if (held_count_ff < COUNT_WIDTH'(HOLD_DEPTH)) begin
                  held_bytes_in[held_count_ff[HOLD_IDX_WIDTH-1:0]] = b;
                  held_count_in = held_count_ff + 1'b1;
                  finish_ok     = eom;
               end else if (held_bytes_ff[0] != SBA_ORDER) begin
                  bundle.res[n] = make_result(KIND_STATUS, saved_att_ff, saved_cur_ff,
                                              '0, '0, '0, STATUS_BAD_ORDER);
                  n             = n + 1'b1;
                  in_field_in   = 1'b0;
                  held_count_in = '0;
                  phase_in      = eom ? PH_AID : PH_SKIP;
               end else begin
                  cur_field_in  = decode_addr(held_bytes_ff[1], held_bytes_ff[2]);
                  byte_off_in   = '0;
                  in_field_in   = 1'b1;
                  held_count_in = '0;
                  scan_now      = 1'b1;
               end
            end
            PH_SKIP: begin
               if (eom) begin
                  phase_in = PH_AID;
               end
            end
            default: begin
               saved_att_in = b;
               if (eom) begin
                  saved_att_in  = '0;
                  saved_cur_in  = '0;
                  bundle.res[n] = make_result(KIND_STATUS, '0, '0, '0, '0, '0,
                                              STATUS_TOO_SHORT);
                  n             = n + 1'b1;
                  phase_in      = PH_AID;
                  in_field_in   = 1'b0;
                  held_count_in = '0;
               end else begin
                  phase_in = PH_CUR1;
               end
            end
         endcase

         // Field data scan: an order byte closes the field, anything else is data.
         if (scan_now) begin
            if (b == SBA_ORDER) begin
               bundle.res[n] = make_result(KIND_DONE, '0, '0, cur_field_in,
                                           byte_off_in, '0, STATUS_OK);
               n                = n + 1'b1;
               in_field_in      = 1'b0;
               held_bytes_in[0] = b;
               held_count_in    = COUNT_WIDTH'(1);
            end else begin
               bundle.res[n] = make_result(KIND_DATA, '0, '0, cur_field_in,
                                           byte_off_in, b, STATUS_OK);
               n = n + 1'b1;
               if (byte_off_in < OFFSET_MAX) begin
                  byte_off_in = byte_off_in + 1'b1;
               end
               if (eom) begin
                  bundle.res[n] = make_result(KIND_DONE, '0, '0, cur_field_in,
                                              byte_off_in, '0, STATUS_OK);
                  n = n + 1'b1;
               end
            end
            finish_ok = eom;
         end

         if (finish_ok) begin
            bundle.res[n] = make_result(KIND_STATUS, saved_att_in, saved_cur_in,
                                        '0, '0, '0, STATUS_OK);
            n             = n + 1'b1;
            phase_in      = PH_AID;
            in_field_in   = 1'b0;
            held_count_in = '0;
         end

         if (n != '0) begin
            bundle.res[n - 1'b1].final_result = 1'b1;
         end
         bundle.count = n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_AID;
         held_count_ff <= '0;
         for (int i = 0; i < HOLD_DEPTH; i++) begin
            held_bytes_ff[i] <= '0;
         end
         saved_att_ff  <= '0;
         saved_cur_ff  <= '0;
         cur_field_ff  <= '0;
         byte_off_ff   <= '0;
         in_field_ff   <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         held_count_ff <= held_count_in;
         held_bytes_ff <= held_bytes_in;
         saved_att_ff  <= saved_att_in;
         saved_cur_ff  <= saved_cur_in;
         cur_field_ff  <= cur_field_in;
         byte_off_ff   <= byte_off_in;
         in_field_ff   <= in_field_in;
      end
   end

endmodule

/* hdl/tifp_result_queue.sv */
// Result queue: takes up to three results per cycle, hands out one per transfer.
// Depends on tifp_pkg.
module tifp_result_queue
   import tifp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bundle_type       bundle,
   input  logic             pop,
   output logic             head_valid,
   output result_type       head,
   output queue_status_type status
);

   result_type                   mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ff, wr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ff, rd_in;
   logic [QUEUE_LEVEL_WIDTH-1:0] level_ff, level_in;
   logic                         do_pop;

   assign head_valid   = (level_ff != '0);
   assign head         = mem[rd_ff];
   assign do_pop       = pop && head_valid;
   assign status.level = level_ff;
   assign status.room  = (level_ff <= QUEUE_LEVEL_WIDTH'(QUEUE_DEPTH - MAX_RESULTS));

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      level_in = level_ff;
      if (push) begin
         wr_in    = wr_ff + QUEUE_PTR_WIDTH'(bundle.count);
         level_in = level_in + QUEUE_LEVEL_WIDTH'(bundle.count);
      end
      if (do_pop) begin
         rd_in    = rd_ff + 1'b1;
         level_in = level_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (COUNT_WIDTH'(i) < bundle.count) begin
               mem[wr_ff + QUEUE_PTR_WIDTH'(i)] <= bundle.res[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

endmodule

/* hdl/terminal_inbound_field_parser.sv */
// Top level of the terminal inbound field parser: input register, parser, result queue.
// Depends on tifp_pkg, tifp_parser and tifp_result_queue.
//
// Usage:
//   Feed one inbound message a byte per transfer on the req_ channel; raise
//   req_end_of_message on the final byte. Results leave on the rsp_ channel:
//   a header, one data result per field byte, a field-done result carrying the
//   field length, and one status per message. rsp_final_result marks the last
//   result caused by a given input byte.
//   Path: a byte accepted into the input register is parsed combinationally and
//   its results are written into the result queue, whose head drives rsp_.
//   Throughput: one byte per cycle. A byte yields up to three results, and the
//   rsp_ side drains one per cycle, so sustained input rate is bounded by the
//   eight-entry result queue: a byte is parsed only while the queue has room
//   for three more results.
//   Reset: synchronous, active high; clears the parser to expect an attention
//   id and empties the queue. Any message in flight is lost.
//   Stall: while rsp_stall is high the head result holds; once the queue
//   cannot take three more results, the held input byte waits and req_stall
//   rises until a slot frees.
module terminal_inbound_field_parser
   import tifp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_stream_byte,
   input  logic                    req_end_of_message,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic [7:0]              rsp_attention_id,
   output logic [ADDR_WIDTH-1:0]   rsp_cursor_offset,
   output logic [ADDR_WIDTH-1:0]   rsp_field_address,
   output logic [OFFSET_WIDTH-1:0] rsp_field_offset,
   output logic [7:0]              rsp_data_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_final_result
);

   item_type         item_ff, item_in;
   logic             item_valid_ff, item_valid_in;
   logic             process;
   bundle_type       bundle;
   result_type       head;
   queue_status_type q_status;

   // Parse the held byte only when the queue can absorb a worst-case burst.
   assign process   = item_valid_ff && q_status.room;
   // Hold the input while the held byte cannot be parsed for lack of queue room.
   assign req_stall = item_valid_ff && !q_status.room;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (!req_stall) begin
         item_valid_in          = req_valid;
         item_in.stream_byte    = req_stream_byte;
         item_in.end_of_message = req_end_of_message;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   tifp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .process (process),
      .item    (item_ff),
      .bundle  (bundle)
   );

   tifp_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (process),
      .bundle     (bundle),
      .pop        (!rsp_stall),
      .head_valid (rsp_valid),
      .head       (head),
      .status     (q_status)
   );

   // Drive the result ports straight from the queue head.
   assign rsp_kind          = head.kind;
   assign rsp_attention_id  = head.attention_id;
   assign rsp_cursor_offset = head.cursor_offset;
   assign rsp_field_address = head.field_address;
   assign rsp_field_offset  = head.field_offset;
   assign rsp_data_value    = head.data_value;
   assign rsp_status        = head.status;
   assign rsp_final_result  = head.final_result;

`ifndef SYNTHESIS
   // Results pushed by the parser must appear at the output on the next cycle.
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (process && bundle.count != '0) |=> rsp_valid)
      else $error("parsed results did not reach the result port");

   // The queue must never hold more than its depth.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= QUEUE_LEVEL_WIDTH'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // A stalled input always has a byte held and waiting for queue room.
   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid_ff && !process))
      else $error("input stalled with no byte pending");
`endif

endmodule

/* verif/terminal_inbound_field_parser_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for terminal_inbound_field_parser: random and directed messages.
// A built-in predictor scores every result; depends on tifp_pkg and the block itself.

module terminal_inbound_field_parser_test;
   import tifp_pkg::*;

   localparam int HALF_PERIOD      = 5;
   localparam int RESET_CYCLES     = 12;
   // Bytes sent by the random part; the directed messages add a couple dozen.
   localparam int RANDOM_ITEMS     = 400;
   // Give the pipe and queue ample room to settle.
   localparam int DRAIN_CYCLES     = 20;
   // Cycles with no transfer on either side before the run is declared hung.
   // A correct run goes quiet only while both sides idle at random (7% idling,
   // queue drains one result per cycle unless stalled), so it stays far below this.
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int IDLE_PERCENT     = 7;
   localparam int MAX_REPORTS      = 20;

   typedef enum logic [2:0] {
      EXPECT_AID,
      EXPECT_CUR1,
      EXPECT_CUR2,
      IN_BODY,
      SKIP_TO_END
   } phase_type;

   // Predicts the results of each accepted byte and scores the results that leave.
   class parse_scoreboard;
      phase_type               phase;
      int unsigned             held_count;
      logic [7:0]              held [HOLD_DEPTH];
      logic [7:0]              saved_aid;
      logic [ADDR_WIDTH-1:0]   saved_cur;
      logic [ADDR_WIDTH-1:0]   field_addr;
      logic [OFFSET_WIDTH-1:0] field_count;
      bit                      in_field;
      result_type              expected_results[$];
      result_type              staged;
      bit                      staged_valid;
      int unsigned             mismatches;
      int unsigned             checked;
      int unsigned             bytes_seen;
      int unsigned             bytes_ignored;
      int unsigned             messages;
      int unsigned             kind_count [4];
      int unsigned             status_count [4];

      function new();
         phase        = EXPECT_AID;
         held_count   = 0;
         foreach (held[i]) held[i] = '0;
         saved_aid    = '0;
         saved_cur    = '0;
         field_addr   = '0;
         field_count  = '0;
         in_field     = 0;
         staged_valid = 0;
      endfunction

      // Stage one result; the last one of a byte gets its final flag later.
      function void emit(kind_type k, logic [7:0] aid, logic [ADDR_WIDTH-1:0] cur,
                         logic [ADDR_WIDTH-1:0] addr, logic [OFFSET_WIDTH-1:0] off,
                         logic [7:0] data, status_type st);
         result_type r;
         if (staged_valid) expected_results.push_back(staged);
         r.kind          = k;
         r.attention_id  = aid;
         r.cursor_offset = cur;
         r.field_address = addr;
         r.field_offset  = off;
         r.data_value    = data;
         r.status        = st;
         r.final_result  = 1'b0;
         staged          = r;
         staged_valid    = 1;
      endfunction

      function void close_message(status_type st);
         emit(KIND_STATUS, saved_aid, saved_cur, '0, '0, '0, st);
         phase      = EXPECT_AID;
         in_field   = 0;
         held_count = 0;
         messages++;
      endfunction

      function void scan_field_byte(logic [7:0] b, bit eom);
         if (b == SBA_ORDER) begin
            emit(KIND_DONE, '0, '0, field_addr, field_count, '0, STATUS_OK);
            in_field   = 0;
            held[0]    = b;
            held_count = 1;
            if (eom) close_message(STATUS_OK);
         end else begin
            emit(KIND_DATA, '0, '0, field_addr, field_count, b, STATUS_OK);
            if (field_count != OFFSET_MAX) field_count++;
            if (eom) begin
               emit(KIND_DONE, '0, '0, field_addr, field_count, '0, STATUS_OK);
               close_message(STATUS_OK);
            end
         end
      endfunction

      function void note_byte(logic [7:0] b, bit eom);
         bytes_seen++;
         case (phase)
            EXPECT_CUR1: begin
               held[0] = b;
               if (eom) begin
                  saved_aid = '0;
                  saved_cur = '0;
                  close_message(STATUS_TOO_SHORT);
               end else begin
                  phase = EXPECT_CUR2;
               end
            end
            EXPECT_CUR2: begin
               saved_cur = {held[0][5:0], b[5:0]};
               emit(KIND_HEADER, saved_aid, saved_cur, '0, '0, '0, STATUS_OK);
               in_field   = 0;
               held_count = 0;
               if (eom) close_message(STATUS_OK);
               else phase = IN_BODY;
            end
            IN_BODY: begin
               if (in_field) begin
                  scan_field_byte(b, eom);
               end else if (held_count < HOLD_DEPTH) begin
                  held[held_count] = b;
                  held_count++;
                  if (eom) close_message(STATUS_OK);
               end else if (held[0] != SBA_ORDER) begin
                  close_message(STATUS_BAD_ORDER);
                  if (!eom) phase = SKIP_TO_END;
               end else begin
                  field_addr  = {held[1][5:0], held[2][5:0]};
                  field_count = '0;
                  in_field    = 1;
                  held_count  = 0;
                  scan_field_byte(b, eom);
               end
            end
            SKIP_TO_END: begin
               bytes_ignored++;
               if (eom) phase = EXPECT_AID;
            end
            default: begin
               saved_aid = b;
               if (eom) begin
                  saved_aid = '0;
                  saved_cur = '0;
                  close_message(STATUS_TOO_SHORT);
               end else begin
                  phase = EXPECT_CUR1;
               end
            end
         endcase
         if (staged_valid) begin
            staged.final_result = 1'b1;
            expected_results.push_back(staged);
            staged_valid = 0;
         end
      endfunction

      function void compare(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with nothing expected, expected none, got kind %0d",
                        $time, got.kind);
            return;
         end
         want = expected_results.pop_front();
         checked++;
         kind_count[want.kind]++;
         if (want.kind == KIND_STATUS) status_count[want.status]++;
         compare("kind",          want.kind,          got.kind);
         compare("attention_id",  want.attention_id,  got.attention_id);
         compare("cursor_offset", want.cursor_offset, got.cursor_offset);
         compare("field_address", want.field_address, got.field_address);
         compare("field_offset",  want.field_offset,  got.field_offset);
         compare("data_value",    want.data_value,    got.data_value);
         compare("status",        want.status,        got.status);
         compare("final_result",  want.final_result,  got.final_result);
      endfunction
   endclass

   // Every input starts at a known value.
   logic                    clock              = 1'b0;
   logic                    reset              = 1'b1;
   logic                    req_valid          = 1'b0;
   logic [7:0]              req_stream_byte    = '0;
   logic                    req_end_of_message = 1'b0;
   logic                    rsp_stall          = 1'b0;
   logic                    req_stall;
   logic                    rsp_valid;
   logic [1:0]              rsp_kind;
   logic [7:0]              rsp_attention_id;
   logic [ADDR_WIDTH-1:0]   rsp_cursor_offset;
   logic [ADDR_WIDTH-1:0]   rsp_field_address;
   logic [OFFSET_WIDTH-1:0] rsp_field_offset;
   logic [7:0]              rsp_data_value;
   logic [1:0]              rsp_status;
   logic                    rsp_final_result;

   // quiet suppresses idling on both sides; req_fire flags an input transfer
   // at the last rising edge so the driver can read it at the falling edge.
   bit              quiet      = 0;
   bit              req_fire   = 0;
   int unsigned     idle_count = 0;
   logic [7:0]      msg[$];
   parse_scoreboard sb         = new();

   always #HALF_PERIOD clock = ~clock;

   terminal_inbound_field_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_attention_id   (rsp_attention_id),
      .rsp_cursor_offset  (rsp_cursor_offset),
      .rsp_field_address  (rsp_field_address),
      .rsp_field_offset   (rsp_field_offset),
      .rsp_data_value     (rsp_data_value),
      .rsp_status         (rsp_status),
      .rsp_final_result   (rsp_final_result)
   );

   // Sample both channels at the rising edge: predict on every input transfer,
   // score every result transfer against the oldest prediction.
   always @(posedge clock) begin
      result_type seen;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         sb.note_byte(req_stream_byte, req_end_of_message);
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind          = kind_type'(rsp_kind);
         seen.attention_id  = rsp_attention_id;
         seen.cursor_offset = rsp_cursor_offset;
         seen.field_address = rsp_field_address;
         seen.field_offset  = rsp_field_offset;
         seen.data_value    = rsp_data_value;
         seen.status        = status_type'(rsp_status);
         seen.final_result  = rsp_final_result;
         sb.check_result(seen);
      end
   end

   // Hang detector: restart the count on any transfer, give up at the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count <= 0;
      end else if (idle_count == WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // Result side: stall at random, except during the quiet stretch.
   always @(negedge clock)
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);

   // Present one byte and hold it until the block takes it. Idle cycles
   // ahead of the byte drop valid; the payload never moves while stalled.
   task automatic send_byte(input logic [7:0] b, input bit eom);
      while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_stream_byte    <= b;
      req_end_of_message <= eom;
      do @(negedge clock); while (!req_fire);
   endtask

   // Transfer the built message, marking its last byte as end of message.
   task automatic send_message();
      foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
      msg.delete();
   endtask

   // Any byte but the set-address order, so field data never closes early.
   function automatic logic [7:0] data_byte();
      logic [7:0] v;
      do v = 8'($urandom); while (v == SBA_ORDER);
      return v;
   endfunction

   // Append an order with a random address and len data bytes.
   function automatic void add_field(int unsigned len);
      msg.push_back(SBA_ORDER);
      msg.push_back(8'($urandom));
      msg.push_back(8'($urandom));
      repeat (len) msg.push_back(data_byte());
   endfunction

   // Mostly well-formed messages with random content; the rest short
   // messages and noise that tends to trip the bad-order check.
   task automatic random_message();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      msg.push_back(8'($urandom));
      if (pick < 6) begin
         if ($urandom_range(0, 1)) msg.push_back(8'($urandom));
      end else if (pick < 16) begin
         repeat ($urandom_range(2, 9))
            msg.push_back(($urandom_range(0, 3) == 0) ? SBA_ORDER : 8'($urandom));
      end else begin
         msg.push_back(8'($urandom));
         msg.push_back(8'($urandom));
         repeat ($urandom_range(0, 4))
            add_field(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
         // Optional trailing order of one to three bytes.
         case ($urandom_range(0, 3))
            1: msg.push_back(SBA_ORDER);
            2: begin
               msg.push_back(SBA_ORDER);
               msg.push_back(8'($urandom));
            end
            3: begin
               msg.push_back(SBA_ORDER);
               msg.push_back(8'($urandom));
               msg.push_back(8'($urandom));
            end
            default: ;
         endcase
      end
      send_message();
   endtask

   initial begin
      int unsigned base;
      int unsigned count;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed: message ending on the attention id, then on the first
      // cursor byte (both too short).
      msg = '{8'hFF};
      send_message();
      msg = '{8'h00, 8'hC0};
      send_message();
      // Header only, cursor at its top value.
      msg = '{8'h7D, 8'hFF, 8'hFF};
      send_message();
      // First order is not a set-address: bad order, then the rest is skipped.
      msg = '{8'h7D, 8'h40, 8'h41, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
      send_message();
      // Field at the top address with two bytes, closed by a new order,
      // then a trailing two-byte order that is ignored.
      msg = '{8'h00, 8'h00, 8'h00, SBA_ORDER, 8'hFF, 8'hFF, 8'hFF, 8'h00,
              SBA_ORDER, SBA_ORDER};
      send_message();

      // Random part, with one stretch where neither side idles.
      base  = sb.bytes_seen;
      count = 0;
      while (sb.bytes_seen - base < RANDOM_ITEMS) begin
         quiet = (count >= 8 && count < 16);
         random_message();
         count++;
      end
      quiet = 0;

      // Drop valid, wait out every expected result, then let the pipe settle.
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.expected_results.size() != 0) sb.mismatches++;

      $display("Run covered %0d bytes in %0d messages (%0d skipped after bad order), %0d results",
               sb.bytes_seen, sb.messages, sb.bytes_ignored, sb.checked);
      $display("Headers %0d, data %0d, field ends %0d, ok %0d, too short %0d, bad order %0d",
               sb.kind_count[KIND_HEADER], sb.kind_count[KIND_DATA], sb.kind_count[KIND_DONE],
               sb.status_count[STATUS_OK], sb.status_count[STATUS_TOO_SHORT],
               sb.status_count[STATUS_BAD_ORDER]);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
